// ----- src/fmcf_pkg.sv -----
// Shared types, codes and field widths for the flight-mode command state machine.
package fmcf_pkg;

    // Stream payload widths (input packed to whole bytes).
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK             = 2'd0,
        STATUS_BAD_TRANSITION = 2'd1,
        STATUS_BAD_COMMAND    = 2'd2,
        STATUS_BACKEND        = 2'd3
    } t_status;

    // Flight state as reported on the result stream.
    localparam logic [2:0] FLIGHT_DISARMED  = 3'd0;
    localparam logic [2:0] FLIGHT_ARMED     = 3'd1;
    localparam logic [2:0] FLIGHT_MANUAL    = 3'd2;
    localparam logic [2:0] FLIGHT_STABILIZE = 3'd3;
    localparam logic [2:0] FLIGHT_LOITER    = 3'd4;
    localparam logic [2:0] FLIGHT_RTL       = 3'd5;
    localparam logic [2:0] FLIGHT_LAND      = 3'd6;

    // Internal one-hot flight state.
    typedef enum logic [6:0] {
        S_DISARMED  = 7'b000_0001,
        S_ARMED     = 7'b000_0010,
        S_MANUAL    = 7'b000_0100,
        S_STABILIZE = 7'b000_1000,
        S_LOITER    = 7'b001_0000,
        S_RTL       = 7'b010_0000,
        S_LAND      = 7'b100_0000
    } t_state;

    // Direct mode request codes.
    localparam logic [2:0] REQ_MANUAL    = 3'd0;
    localparam logic [2:0] REQ_STABILIZE = 3'd1;
    localparam logic [2:0] REQ_LOITER    = 3'd2;
    localparam logic [2:0] REQ_RTL       = 3'd3;
    localparam logic [2:0] REQ_LAND      = 3'd4;
    localparam logic [2:0] REQ_ARM       = 3'd5;
    localparam logic [2:0] REQ_DISARM    = 3'd6;

    // Command codes.
    localparam logic [15:0] CMD_ARM_DISARM = 16'd400;
    localparam logic [15:0] CMD_RTL        = 16'd20;
    localparam logic [15:0] CMD_LAND       = 16'd21;
    localparam logic [15:0] CMD_SET_MODE   = 16'd176;

    // Set-mode main and sub mode numbers.
    localparam logic [7:0] MAIN_MANUAL    = 8'd1;
    localparam logic [7:0] MAIN_AUTO      = 8'd4;
    localparam logic [7:0] MAIN_STABILIZE = 8'd7;
    localparam logic [7:0] SUB_LOITER     = 8'd3;
    localparam logic [7:0] SUB_RTL        = 8'd5;
    localparam logic [7:0] SUB_LAND       = 8'd6;

    // Tolerance 0.001 as single bits and as a 33-fraction-bit fixed value.
    localparam logic [30:0] TOL_BITS = 31'h3A83126F;
    localparam logic [37:0] TOL_FIX  = 38'h0000_83126F;

endpackage

// ----- src/flight_mode_command_fsm_core.sv -----
// Flight-mode command state machine with stream input and result channels.
//
// This block tracks one of seven flight states (disarmed, armed, manual, stabilize,
// loiter, return-to-launch, land) and answers every input transfer with exactly one
// result transfer carrying a status and the flight state after the item. An item is
// either a direct mode request (tuser bit 0 low) or an encoded command (tuser bit 0
// high) whose two parameters are IEEE single values; arm/disarm, return-to-launch,
// land and set-mode commands are decoded with exact fixed-point window tests, so no
// floating-point unit is present. Each item is captured in an input register, decoded
// and applied to the state when the result register advances, and the result sits in
// an output register: one item per clock is sustained while the result side does not
// stall, and the state update loop sets that rate. While a result waits on the output,
// the input side accepts one more item only if the input register is empty.
// The one configuration bit, backend_attached, makes backend_ok decide whether a
// permitted change takes effect; write it only while no item is in flight.
module flight_mode_command_fsm_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low bit up: mode_request[2:0], command_code[18:3], param_one_bits[50:19],
    // param_two_bits[82:51], backend_ok[83], zero fill[87:84].
    input  logic [fmcf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func[0].
    input  logic [fmcf_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low bit up: status[1:0], flight_state[4:2], zero fill[7:5].
    output logic [fmcf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write channel: backend_attached.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);
    import fmcf_pkg::*;

    // True when the single p lies strictly within 0.001 of zero.
    function automatic logic near_zero(input logic [31:0] p);
        near_zero = (p[30:0] < TOL_BITS);
    endfunction

    // True when the single p lies strictly within 0.001 of the small integer e.
    // The significand is aligned to 33 fraction bits; only exponents 126..131 can match.
    function automatic logic near_int(input logic [31:0] p, input logic [3:0] e);
        logic [7:0]  ex;
        logic [3:0]  shamt;
        logic [37:0] fv;
        logic [37:0] ef;
        logic [37:0] diff;
        ex    = p[30:23];
        shamt = 4'(ex - 8'd117);
        fv    = {14'b0, 1'b1, p[22:0]} << shamt;
        ef    = {1'b0, e, 33'b0};
        diff  = (fv > ef) ? (fv - ef) : (ef - fv);
        near_int = !p[31] && (ex >= 8'd126) && (ex <= 8'd131) && (diff < TOL_FIX);
    endfunction

    // Saturating truncation of a single to a 32-bit unsigned value.
    function automatic logic [31:0] to_uint(input logic [31:0] p);
        logic [7:0]  ex;
        logic [4:0]  sh;
        logic [31:0] mant;
        ex   = p[30:23];
        sh   = 5'(ex - 8'd127);
        mant = {8'b0, 1'b1, p[22:0]};
        if (ex == 8'hFF && p[22:0] != 23'd0) begin
            to_uint = 32'd0;
        end else if (p[31] || ex < 8'd127) begin
            to_uint = 32'd0;
        end else if (ex >= 8'd159) begin
            to_uint = 32'hFFFF_FFFF;
        end else if (sh >= 5'd23) begin
            to_uint = mant << (sh - 5'd23);
        end else begin
            to_uint = mant >> (5'd23 - sh);
        end
    endfunction

    // Target state of a permitted request.
    function automatic t_state req_target(input logic [2:0] req);
        unique case (req)
            REQ_MANUAL:    req_target = S_MANUAL;
            REQ_STABILIZE: req_target = S_STABILIZE;
            REQ_LOITER:    req_target = S_LOITER;
            REQ_RTL:       req_target = S_RTL;
            REQ_LAND:      req_target = S_LAND;
            REQ_ARM:       req_target = S_ARMED;
            default:       req_target = S_DISARMED;
        endcase
    endfunction

    // One-hot state to the reported flight state code.
    function automatic logic [2:0] state_code(input t_state s);
        unique case (s)
            S_DISARMED:  state_code = FLIGHT_DISARMED;
            S_ARMED:     state_code = FLIGHT_ARMED;
            S_MANUAL:    state_code = FLIGHT_MANUAL;
            S_STABILIZE: state_code = FLIGHT_STABILIZE;
            S_LOITER:    state_code = FLIGHT_LOITER;
            S_RTL:       state_code = FLIGHT_RTL;
            S_LAND:      state_code = FLIGHT_LAND;
            default:     state_code = FLIGHT_DISARMED;
        endcase
    endfunction

    // Input register.
    logic        r_in_valid;
    logic        r_func;
    logic [2:0]  r_mode_request;
    logic [15:0] r_command_code;
    logic [31:0] r_param_one_bits;
    logic [31:0] r_param_two_bits;
    logic        r_backend_ok;

    // Flight state and configuration.
    t_state      r_state;
    t_state      n_state;
    logic        r_backend_attached;

    // Result register.
    logic        r_out_valid;
    t_status     r_status;
    t_status     n_status;
    logic [2:0]  r_flight_state;

    logic        advance;
    logic        in_fire;
    logic [31:0] p2_uint;
    logic [7:0]  mode_major;
    logic [7:0]  mode_minor;

    // The result register moves on when it is empty or its transfer completes;
    // the input register can then always hand its item forward.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_flight_state, r_status};

    assign p2_uint    = to_uint(r_param_two_bits);
    assign mode_major = p2_uint[23:16];
    assign mode_minor = p2_uint[31:24];

    // Decode the item into a request code, then apply the transition rules.
    always_comb begin
        logic       have_req;
        logic [2:0] req;
        logic       allowed;
        have_req = 1'b0;
        req      = REQ_MANUAL;
        allowed  = 1'b0;
        n_status = STATUS_OK;
        n_state  = r_state;

        if (!r_func) begin
            have_req = 1'b1;
            req      = r_mode_request;
        end else begin
            unique case (r_command_code)
                CMD_ARM_DISARM: begin
                    if (near_int(r_param_one_bits, 4'd1)) begin
                        have_req = 1'b1;
                        req      = REQ_ARM;
                    end else if (near_zero(r_param_one_bits)) begin
                        have_req = 1'b1;
                        req      = REQ_DISARM;
                    end
                end
                CMD_RTL: begin
                    have_req = 1'b1;
                    req      = REQ_RTL;
                end
                CMD_LAND: begin
                    have_req = 1'b1;
                    req      = REQ_LAND;
                end
                CMD_SET_MODE: begin
                    // Small mode numbers win over the packed main/sub form.
                    have_req = 1'b1;
                    if (near_zero(r_param_two_bits)) begin
                        req = REQ_MANUAL;
                    end else if (near_int(r_param_two_bits, 4'd2)) begin
                        req = REQ_STABILIZE;
                    end else if (near_int(r_param_two_bits, 4'd5)) begin
                        req = REQ_LOITER;
                    end else if (near_int(r_param_two_bits, 4'd6)) begin
                        req = REQ_RTL;
                    end else if (near_int(r_param_two_bits, 4'd9)) begin
                        req = REQ_LAND;
                    end else if (mode_major == MAIN_MANUAL) begin
                        req = REQ_MANUAL;
                    end else if (mode_major == MAIN_STABILIZE) begin
                        req = REQ_STABILIZE;
                    end else if (mode_major == MAIN_AUTO && mode_minor == SUB_LOITER) begin
                        req = REQ_LOITER;
                    end else if (mode_major == MAIN_AUTO && mode_minor == SUB_RTL) begin
                        req = REQ_RTL;
                    end else if (mode_major == MAIN_AUTO && mode_minor == SUB_LAND) begin
                        req = REQ_LAND;
                    end else begin
                        have_req = 1'b0;
                    end
                end
                default: begin
                    have_req = 1'b0;
                end
            endcase
        end

        if (!have_req) begin
            n_status = STATUS_BAD_COMMAND;
        end else begin
            // Arming needs disarmed; any other defined request needs a state other than disarmed.
            if (req == REQ_ARM) begin
                allowed = (r_state == S_DISARMED);
            end else begin
                allowed = (r_state != S_DISARMED) && (req <= REQ_DISARM);
            end
            if (!allowed) begin
                n_status = STATUS_BAD_TRANSITION;
            end else if (r_backend_attached && !r_backend_ok) begin
                n_status = STATUS_BACKEND;
            end else begin
                n_state = req_target(req);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state            <= S_DISARMED;
            r_backend_attached <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_backend_attached <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func           <= s_axis_tuser[0];
            r_mode_request   <= s_axis_tdata[2:0];
            r_command_code   <= s_axis_tdata[18:3];
            r_param_one_bits <= s_axis_tdata[50:19];
            r_param_two_bits <= s_axis_tdata[82:51];
            r_backend_ok     <= s_axis_tdata[83];
        end
        if (advance && r_in_valid) begin
            r_status       <= n_status;
            r_flight_state <= state_code(n_state);
        end
    end

endmodule

// ----- src/fmcf_checker.sv -----
// Port-level checker for the flight-mode command state machine, bound to the top level.
module fmcf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fmcf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [fmcf_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fmcf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic                            i_cfg_data
);
    import fmcf_pkg::*;

    logic       out_fire;
    logic [1:0] out_status;
    logic [2:0] out_flight;
    logic [2:0] r_last_flight;
    logic       r_attached;
    logic       in_seen;

    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign out_status = m_axis_tdata[1:0];
    assign out_flight = m_axis_tdata[4:2];
    assign in_seen    = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tuser != '0);

    // Flight state of the last delivered result and the configuration seen so far.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_flight <= FLIGHT_DISARMED;
            r_attached    <= 1'b0;
        end else begin
            if (out_fire) begin
                r_last_flight <= out_flight;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_attached <= i_cfg_data;
            end
        end
    end

    // A refused or failed item leaves the flight state where it was.
    a_hold_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && out_status != STATUS_OK |-> out_flight == r_last_flight)
        else $error("flight state changed on a failed item");

    // A backend error needs an attached backend.
    a_backend_needs_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && out_status == STATUS_BACKEND |-> r_attached)
        else $error("backend error reported without a backend");

    // No successful change can both start and end in disarmed.
    a_no_disarmed_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && out_status == STATUS_OK |->
            !(r_last_flight == FLIGHT_DISARMED && out_flight == FLIGHT_DISARMED))
        else $error("successful change while staying disarmed");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Nothing is shown as valid right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && !in_seen |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind flight_mode_command_fsm_core fmcf_checker u_fmcf_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the flight-mode command state machine core.
`timescale 1ns / 1ps

module tb;
    import fmcf_pkg::*;

    // Quiet cycles (no transfer on any channel) before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed after the last expected result before a config write or the end.
    localparam int SETTLE_CYCLES = 4;

    // Request code that names no mode at all.
    localparam logic [2:0] REQ_UNDEFINED = 3'd7;

    // Tolerance 0.001 as single bits, and as a fixed value with 33 fraction bits.
    localparam logic [31:0] TOL_SINGLE = 32'h3A83126F;
    localparam logic [63:0] TOL_FIXED  = 64'h83126F;

    // Single-precision encodings used by the directed items.
    localparam logic [31:0] SGL_ZERO     = 32'h0000_0000;
    localparam logic [31:0] SGL_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] SGL_ONE      = 32'h3F80_0000;
    localparam logic [31:0] SGL_TWO      = 32'h4000_0000;
    localparam logic [31:0] SGL_FIVE     = 32'h40A0_0000;
    localparam logic [31:0] SGL_NINE     = 32'h4110_0000;
    localparam logic [31:0] SGL_POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] SGL_NEG_INF  = 32'hFF80_0000;
    localparam logic [31:0] SGL_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] SGL_TWO_P32  = 32'h4F80_0000;

    typedef struct {
        logic        func;
        logic [2:0]  req;
        logic [15:0] code;
        logic [31:0] p_one;
        logic [31:0] p_two;
        logic        ok;
    } flight_item_t;

    typedef struct packed {
        t_status    status;
        logic [2:0] state;
    } flight_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_data;

    // Shadow copy of the machine: flight state and the backend switch.
    logic [2:0]     flight_now;
    logic           backend_on;
    flight_result_t pending_results[$];

    int mismatch_count = 0;
    int result_count   = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    flight_mode_command_fsm_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Flight-state predictor
    // ------------------------------------------------------------------

    // Exact window test |p - e| < 0.001 for the small set of targets; NaN never matches.
    function automatic bit near_match(logic [31:0] p, int unsigned e);
        int          sh;
        logic [63:0] fv;
        logic [63:0] ef;
        logic [63:0] diff;
        if (e == 0)
            return {1'b0, p[30:0]} < TOL_SINGLE;
        if (p[31])
            return 1'b0;
        if (p[30:23] < 8'd126 || p[30:23] > 8'd131)
            return 1'b0;
        sh   = int'(p[30:23]) - 117;
        fv   = 64'({1'b1, p[22:0]}) << sh;
        ef   = 64'(e) << 33;
        diff = (fv > ef) ? fv - ef : ef - fv;
        return diff < TOL_FIXED;
    endfunction

    // Truncates a single to an unsigned word; NaN, negatives and values below one give
    // zero, and anything at or above two to the 32nd saturates.
    function automatic logic [31:0] single_to_word(logic [31:0] p);
        int          u;
        logic [63:0] mant;
        mant = 64'({1'b1, p[22:0]});
        if (p[30:23] == 8'hFF && p[22:0] != 23'd0)
            return 32'd0;
        if (p[31] || p[30:23] < 8'd127)
            return 32'd0;
        if (p[30:23] >= 8'd159)
            return 32'hFFFF_FFFF;
        u = int'(p[30:23]) - 127;
        if (u >= 23)
            return 32'(mant << (u - 23));
        return 32'(mant >> (23 - u));
    endfunction

    // Applies one mode request to the shadow state and returns its status.
    function automatic t_status apply_change(logic [2:0] req, logic ok);
        logic [2:0] goal;
        case (req)
            REQ_MANUAL:    goal = FLIGHT_MANUAL;
            REQ_STABILIZE: goal = FLIGHT_STABILIZE;
            REQ_LOITER:    goal = FLIGHT_LOITER;
            REQ_RTL:       goal = FLIGHT_RTL;
            REQ_LAND:      goal = FLIGHT_LAND;
            REQ_ARM:       goal = FLIGHT_ARMED;
            REQ_DISARM:    goal = FLIGHT_DISARMED;
            default:       return STATUS_BAD_TRANSITION;
        endcase
        // Arming only from disarmed; everything else only once armed.
        if (req == REQ_ARM) begin
            if (flight_now != FLIGHT_DISARMED)
                return STATUS_BAD_TRANSITION;
        end else if (flight_now == FLIGHT_DISARMED) begin
            return STATUS_BAD_TRANSITION;
        end
        if (backend_on && !ok)
            return STATUS_BACKEND;
        flight_now = goal;
        return STATUS_OK;
    endfunction

    function automatic t_status decode_command(flight_item_t it);
        logic [31:0] w;
        logic [7:0]  mode_major;
        logic [7:0]  mode_minor;
        case (it.code)
            CMD_ARM_DISARM: begin
                if (near_match(it.p_one, 1))
                    return apply_change(REQ_ARM, it.ok);
                if (near_match(it.p_one, 0))
                    return apply_change(REQ_DISARM, it.ok);
                return STATUS_BAD_COMMAND;
            end
            CMD_RTL:      return apply_change(REQ_RTL, it.ok);
            CMD_LAND:     return apply_change(REQ_LAND, it.ok);
            CMD_SET_MODE: ;
            default:      return STATUS_BAD_COMMAND;
        endcase
        // Set mode: small mode numbers first, then the packed main/sub word.
        if (near_match(it.p_two, 0)) return apply_change(REQ_MANUAL, it.ok);
        if (near_match(it.p_two, 2)) return apply_change(REQ_STABILIZE, it.ok);
        if (near_match(it.p_two, 5)) return apply_change(REQ_LOITER, it.ok);
        if (near_match(it.p_two, 6)) return apply_change(REQ_RTL, it.ok);
        if (near_match(it.p_two, 9)) return apply_change(REQ_LAND, it.ok);
        w          = single_to_word(it.p_two);
        mode_major = w[23:16];
        mode_minor = w[31:24];
        if (mode_major == MAIN_MANUAL)
            return apply_change(REQ_MANUAL, it.ok);
        if (mode_major == MAIN_STABILIZE)
            return apply_change(REQ_STABILIZE, it.ok);
        if (mode_major == MAIN_AUTO) begin
            if (mode_minor == SUB_LOITER) return apply_change(REQ_LOITER, it.ok);
            if (mode_minor == SUB_RTL)    return apply_change(REQ_RTL, it.ok);
            if (mode_minor == SUB_LAND)   return apply_change(REQ_LAND, it.ok);
        end
        return STATUS_BAD_COMMAND;
    endfunction

    function automatic flight_result_t predict_flight(flight_item_t it);
        flight_result_t r;
        r.status = it.func ? decode_command(it) : apply_change(it.req, it.ok);
        r.state  = flight_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    // Single encoding of an unsigned word; low bits beyond 24 significant bits drop.
    function automatic logic [31:0] word_to_single(logic [31:0] v);
        int          k;
        logic [31:0] mant;
        k = 0;
        for (int i = 0; i < 32; i++)
            if (v[i])
                k = i;
        if (v == 32'd0)
            return SGL_ZERO;
        if (k >= 23)
            mant = v >> (k - 23);
        else
            mant = v << (23 - k);
        return {1'b0, 8'(127 + k), mant[22:0]};
    endfunction

    function automatic flight_item_t req_item(logic [2:0] req, logic ok);
        flight_item_t it;
        it = '{func: 1'b0, req: req, code: 16'd0, p_one: 32'd0, p_two: 32'd0, ok: ok};
        return it;
    endfunction

    function automatic flight_item_t cmd_item(logic [15:0] code, logic [31:0] p_one,
                                              logic [31:0] p_two, logic ok);
        flight_item_t it;
        it = '{func: 1'b1, req: 3'd0, code: code, p_one: p_one, p_two: p_two, ok: ok};
        return it;
    endfunction

    // A parameter scattered around the edge of the window for target e.
    function automatic logic [31:0] param_near(int unsigned e);
        int          jit;
        logic [31:0] p;
        jit = int'($urandom_range(0, 32768)) - 16384;
        if (e == 0 && $urandom_range(0, 1) == 0)
            return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h3A80_0000))};
        p = ((e == 0) ? TOL_SINGLE : word_to_single(e)) + 32'(jit);
        if (e == 0)
            p[31] = 1'($urandom_range(0, 1));
        return p;
    endfunction

    function automatic logic [31:0] mode_param();
        logic [7:0] mode_major;
        logic [7:0] mode_minor;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                case ($urandom_range(0, 4))
                    0: return param_near(0);
                    1: return param_near(2);
                    2: return param_near(5);
                    3: return param_near(6);
                    default: return param_near(9);
                endcase
            end
            4, 5, 6: begin
                case ($urandom_range(0, 3))
                    0: mode_major = MAIN_MANUAL;
                    1: mode_major = MAIN_STABILIZE;
                    2: mode_major = MAIN_AUTO;
                    default: mode_major = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: mode_minor = SUB_LOITER;
                    1: mode_minor = SUB_RTL;
                    2: mode_minor = SUB_LAND;
                    default: mode_minor = 8'($urandom);
                endcase
                return word_to_single({mode_minor, mode_major, 16'($urandom)});
            end
            7, 8: begin
                case ($urandom_range(0, 5))
                    0: return SGL_POS_INF;
                    1: return SGL_NEG_INF;
                    2: return SGL_QNAN | 32'($urandom_range(0, 32'h003F_FFFF));
                    3: return SGL_NEG_ZERO | 32'($urandom);
                    4: return SGL_TWO_P32;
                    default: return {1'b0, 8'($urandom_range(159, 254)), 23'($urandom)};
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests and commands, so the machine spends most of its
    // time armed and moving between modes; a tenth of the items is pure noise.
    function automatic flight_item_t random_item();
        flight_item_t it;
        int           pick;
        it.func  = 1'($urandom_range(0, 1));
        it.req   = 3'($urandom);
        it.code  = 16'($urandom);
        it.p_one = $urandom;
        it.p_two = $urandom;
        it.ok    = ($urandom_range(0, 99) < 80);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return it;
        if (pick < 45) begin
            it.func = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                it.req = REQ_ARM;
            else if (pick < 23)
                it.req = REQ_DISARM;
            else if (pick < 26)
                it.req = REQ_UNDEFINED;
            else
                it.req = 3'($urandom_range(0, 4));
            return it;
        end
        it.func = 1'b1;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                it.code = CMD_ARM_DISARM;
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    it.p_one = param_near(1);
                else if (pick < 8)
                    it.p_one = param_near(0);
            end
            3: it.code = CMD_RTL;
            4: it.code = CMD_LAND;
            9: ;
            default: begin
                it.code  = CMD_SET_MODE;
                it.p_two = mode_param();
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers; inputs move on the falling edge only
    // ------------------------------------------------------------------

    // Sends one item, after a random gap, and records its predicted result at the
    // edge where the transfer happens.
    task automatic send_item(flight_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'd0, it.ok, it.p_two, it.p_one, it.code, it.req};
        s_axis_tuser  = it.func;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(predict_flight(it));
    endtask

    // Holds the input side off until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_backend(logic attached);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = attached;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        backend_on = attached;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver backpressure, redrawn every cycle.
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Result checking and the hang watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        flight_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          result_count));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("result %0d: status %0d, predicted %0d",
                                              result_count, m_axis_tdata[1:0], want.status));
                if (m_axis_tdata[4:2] !== want.state)
                    report_mismatch($sformatf("result %0d: flight state %0d, predicted %0d",
                                              result_count, m_axis_tdata[4:2], want.state));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Direct requests from reset: refusals while disarmed, arming twice, every
    // mode, the undefined request code and disarming.
    task automatic test_direct_requests();
        write_backend(1'b0);
        send_item(req_item(REQ_MANUAL, 1'b1));
        send_item(req_item(REQ_DISARM, 1'b0));
        send_item(req_item(REQ_ARM, 1'b0));
        send_item(req_item(REQ_ARM, 1'b1));
        send_item(req_item(REQ_MANUAL, 1'b1));
        send_item(req_item(REQ_STABILIZE, 1'b0));
        send_item(req_item(REQ_LOITER, 1'b1));
        send_item(req_item(REQ_RTL, 1'b1));
        send_item(req_item(REQ_LAND, 1'b1));
        send_item(req_item(REQ_UNDEFINED, 1'b1));
        send_item(req_item(REQ_DISARM, 1'b1));
    endtask

    // Command decode: window hits, NaN, infinity, negative zero, the packed
    // main/sub mode word, unknown codes with all-ones fields.
    task automatic test_command_decode();
        send_item(cmd_item(CMD_ARM_DISARM, SGL_ONE, SGL_ZERO, 1'b1));
        send_item(cmd_item(CMD_ARM_DISARM, SGL_QNAN, SGL_TWO, 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO, SGL_TWO, 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO, SGL_NINE + 32'd1, 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO,
                           word_to_single({SUB_LOITER, MAIN_AUTO, 16'd0}), 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO,
                           word_to_single({8'd0, MAIN_MANUAL, 16'd0}), 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO, SGL_POS_INF, 1'b1));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO, SGL_NEG_ZERO, 1'b1));
        send_item(cmd_item(CMD_RTL, SGL_NEG_INF, SGL_QNAN, 1'b1));
        send_item(cmd_item(CMD_LAND, SGL_ZERO, SGL_ZERO, 1'b1));
        send_item('{func: 1'b1, req: 3'h7, code: 16'hFFFF, p_one: 32'hFFFF_FFFF,
                    p_two: 32'hFFFF_FFFF, ok: 1'b1});
        send_item(cmd_item(CMD_ARM_DISARM, SGL_ZERO, 32'hFFFF_FFFF, 1'b0));
    endtask

    // Backend attached: a failed acknowledgement keeps the state, while a refused
    // transition reports as refused whatever the backend says.
    task automatic test_backend_ack();
        write_backend(1'b1);
        send_item(req_item(REQ_ARM, 1'b0));
        send_item(req_item(REQ_ARM, 1'b1));
        send_item(req_item(REQ_ARM, 1'b0));
        send_item(cmd_item(CMD_SET_MODE, SGL_ZERO, SGL_FIVE, 1'b0));
    endtask

    // Random traffic under one idling profile, with a full drain halfway through.
    task automatic test_random_traffic(int count, int send_pct, int recv_pct,
                                       logic attached);
        write_backend(attached);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                wait_drained();
            send_item(random_item());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        flight_now    = FLIGHT_DISARMED;
        backend_on    = 1'b0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_direct_requests();
        test_command_decode();
        test_backend_ack();
        test_random_traffic(210, 0, 0, 1'b0);
        test_random_traffic(210, 60, 0, 1'b1);
        test_random_traffic(210, 0, 60, 1'b0);
        test_random_traffic(210, 9, 9, 1'b1);

        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
src/fmcf_pkg.sv
src/flight_mode_command_fsm_core.sv
src/fmcf_checker.sv
tb/tb.sv
